FILE: hw/rtl/perspective_projection_viewport_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the perspective projection viewport
// Implication checks clocked on clk, idle while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_PROJECTION_VIEWPORT_MACROS_SVH
`define PERSPECTIVE_PROJECTION_VIEWPORT_MACROS_SVH

// same-cycle implication
`define PPV_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppv assertion failed");

// next-cycle implication
`define PPV_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppv assertion failed");

`endif

FILE: hw/rtl/ppv_pkg.sv
// ---------------------------------------------------------------------------
// ppv_pkg
// Types, widths and register codes shared by the projection blocks.
// ---------------------------------------------------------------------------
`default_nettype none

package ppv_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int CW         = 32;                 // coefficient / coordinate width
	localparam int DW         = 66 - FRAC_BITS;     // clip coordinate width
	localparam int NW         = DW + 1;             // numerator / denominator width
	localparam int SW         = 14;                 // viewport size width
	localparam int PW         = NW + SW;            // size * numerator
	localparam int RW         = NW + 1;             // divider remainder
	localparam int QW         = 32;                 // quotient bits
	localparam int LOWW       = QW - FRAC_BITS;     // low product bits shifted into the divider
	localparam int W_MIN      = (1 << FRAC_BITS) / 100;
	localparam int FIFO_DEPTH = 4;
	localparam int FAW        = $clog2(FIFO_DEPTH);
	localparam int FCW        = FAW + 1;

	typedef enum logic [2:0] {
		REG_ROW_X_A = 3'd0,
		REG_ROW_X_B = 3'd1,
		REG_ROW_Y_A = 3'd2,
		REG_ROW_Y_B = 3'd3,
		REG_ROW_W_A = 3'd4,
		REG_ROW_W_B = 3'd5,
		REG_VP_W    = 3'd6,
		REG_VP_H    = 3'd7
	} ppv_reg_e;

	typedef struct packed {
		logic signed [CW-1:0] world_x;
		logic signed [CW-1:0] world_y;
		logic signed [CW-1:0] world_z;
	} ppv_point_t;

	typedef struct packed {
		logic                 in_front;
		logic signed [CW-1:0] screen_x;
		logic signed [CW-1:0] screen_y;
	} ppv_result_t;

	typedef logic [5:0][63:0] ppv_mat_t;

	// classified item handed from front to back
	typedef struct packed {
		logic          in_front;
		logic          neg_x;
		logic [NW-1:0] mag_x;
		logic          neg_y;
		logic [NW-1:0] mag_y;
		logic [NW-1:0] den;
	} ppv_job_t;

	typedef struct packed {
		logic v_s1;
		logic v_s2;
		logic v_s3;
	} ppv_front_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/perspective_projection_viewport.sv
// ---------------------------------------------------------------------------
// perspective_projection_viewport
// World point to viewport pixel projection, Q16.16 in and out.
// ---------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------
//  point in  | start & !busy             | point (world_x/y/z)
//  result    | done strobe, one cycle    | result (in_front, screen_x/y)
//  config    | cfg_valid & cfg_ready     | cfg_index, cfg_data
//
// One point per cycle sustained while busy is low. A point passes 3 front
// stages, the queue, 2 back setup stages, 32 divider stages (one quotient bit
// each) and the output register.
// Reset clears valid bits and queue pointers; config resets to an identity-free
// zero matrix and a 1920x1200 viewport. Results cannot be stalled; the back
// end drains the queue every cycle, so busy only rises if the points in flight could overfill the queue.
// ---------------------------------------------------------------------------
`default_nettype none

`include "perspective_projection_viewport_macros.svh"

module perspective_projection_viewport import ppv_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire ppv_point_t   point,
	output logic              done,
	output ppv_result_t       result,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire ppv_reg_e     cfg_index,
	input  wire logic [63:0]  cfg_data
);

	// configuration registers
	ppv_mat_t      mat_q;
	logic [SW-1:0] vp_w_q, vp_h_q;

	ppv_front_stat_t fstat;
	logic            push, pop, empty;
	ppv_job_t        fjob, head;
	logic [FCW-1:0]  fifo_cnt;
	logic [FCW:0]    occ;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q  <= '0;
			vp_w_q <= SW'(1920);
			vp_h_q <= SW'(1200);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW_X_A: mat_q[0] <= cfg_data;
				REG_ROW_X_B: mat_q[1] <= cfg_data;
				REG_ROW_Y_A: mat_q[2] <= cfg_data;
				REG_ROW_Y_B: mat_q[3] <= cfg_data;
				REG_ROW_W_A: mat_q[4] <= cfg_data;
				REG_ROW_W_B: mat_q[5] <= cfg_data;
				REG_VP_W:    vp_w_q   <= cfg_data[SW-1:0];
				REG_VP_H:    vp_h_q   <= cfg_data[SW-1:0];
				default:     mat_q    <= mat_q;
			endcase
		end
	end

	// hold off new points when everything in flight could overrun the queue;
	// the entry leaving this cycle frees its slot
	assign occ  = (FCW+1)'(fifo_cnt) - (FCW+1)'(pop) + (FCW+1)'(fstat.v_s1)
		+ (FCW+1)'(fstat.v_s2) + (FCW+1)'(fstat.v_s3);
	assign busy = occ >= (FCW+1)'(FIFO_DEPTH);
	assign pop  = !empty;

	ppv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start && !busy),
		.point  (point),
		.mat    (mat_q),
		.push   (push),
		.job    (fjob),
		.stat   (fstat)
	);

	ppv_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (fjob),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.count   (fifo_cnt)
	);

	ppv_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (pop),
		.job    (head),
		.vp_w   (vp_w_q),
		.vp_h   (vp_h_q),
		.done   (done),
		.result (result)
	);

	// accepted point enters the first front stage
	`PPV_ASSERT_NXT(a_take_s1, start && !busy, fstat.v_s1)
	// queue never written while full
	`PPV_ASSERT_IMP(a_fifo_room, push && !pop, fifo_cnt < FCW'(FIFO_DEPTH))
	// hidden points report zero coordinates
	`PPV_ASSERT_IMP(a_hidden_zero, done && !result.in_front, result.screen_x == '0 && result.screen_y == '0)

endmodule

`default_nettype wire

FILE: hw/rtl/ppv_front.sv
// ---------------------------------------------------------------------------
// ppv_front
// Clip-space dot products, visibility test and numerator setup.
// ---------------------------------------------------------------------------
`default_nettype none

module ppv_front import ppv_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire ppv_point_t      point,
	input  wire ppv_mat_t        mat,
	output logic                 push,
	output ppv_job_t             job,
	output ppv_front_stat_t      stat
);

	logic v_s1, v_s2, v_s3;
	logic signed [63:0]   prod_s1 [0:2][0:2];
	logic signed [CW-1:0] trans_s1 [0:2];
	logic signed [DW-1:0] dot_s2 [0:2];
	logic signed [NW-1:0] num_x_s3, num_y_s3;
	logic [NW-1:0]        den_s3;
	logic                 inf_s3;
	logic signed [DW-1:0] dot_c [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// s1: nine exact products; row r uses mat[2r] and mat[2r+1]
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			prod_s1[r][0] <= 64'(signed'(mat[2*r][31:0]))    * 64'(point.world_x);
			prod_s1[r][1] <= 64'(signed'(mat[2*r][63:32]))   * 64'(point.world_y);
			prod_s1[r][2] <= 64'(signed'(mat[2*r+1][31:0]))  * 64'(point.world_z);
			trans_s1[r]   <= signed'(mat[2*r+1][63:32]);
		end
	end

	// floor each product, then sum with translation
	always_comb begin
		logic signed [63:0] a, b, c;
		for (int r = 0; r < 3; r++) begin
			a = prod_s1[r][0] >>> FRAC_BITS;
			b = prod_s1[r][1] >>> FRAC_BITS;
			c = prod_s1[r][2] >>> FRAC_BITS;
			dot_c[r] = DW'(a) + DW'(b) + DW'(c) + DW'(trans_s1[r]);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			dot_s2[r] <= dot_c[r];
		end
	end

	// s3: w + x, w - y, 2w, visibility
	always_ff @(posedge clk) begin
		num_x_s3 <= NW'(dot_s2[2]) + NW'(dot_s2[0]);
		num_y_s3 <= NW'(dot_s2[2]) - NW'(dot_s2[1]);
		den_s3   <= {dot_s2[2], 1'b0};
		inf_s3   <= dot_s2[2] >= DW'(W_MIN);
	end

	always_comb begin
		push         = v_s3;
		job.in_front = inf_s3;
		job.neg_x    = num_x_s3[NW-1];
		job.mag_x    = num_x_s3[NW-1] ? NW'(-num_x_s3) : NW'(num_x_s3);
		job.neg_y    = num_y_s3[NW-1];
		job.mag_y    = num_y_s3[NW-1] ? NW'(-num_y_s3) : NW'(num_y_s3);
		job.den      = den_s3;
		stat.v_s1    = v_s1;
		stat.v_s2    = v_s2;
		stat.v_s3    = v_s3;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ppv_fifo.sv
// ---------------------------------------------------------------------------
// ppv_fifo
// Short queue of classified items between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module ppv_fifo import ppv_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire ppv_job_t wr_data,
	input  wire logic     pop,
	output ppv_job_t      head,
	output logic          empty,
	output logic [FCW-1:0] count
);

	ppv_job_t       mem [0:FIFO_DEPTH-1];
	logic [FAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + FCW'(push) - FCW'(pop);
		end
	end

	assign head  = mem[rd_ptr_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ppv_back.sv
// ---------------------------------------------------------------------------
// ppv_back
// Viewport scaling and two pipelined restoring dividers, one bit a stage.
// ---------------------------------------------------------------------------
`default_nettype none

module ppv_back import ppv_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire ppv_job_t      job,
	input  wire logic [SW-1:0] vp_w,
	input  wire logic [SW-1:0] vp_h,
	output logic               done,
	output ppv_result_t        result
);

	localparam int HW = PW - LOWW;

	logic          v_b1;
	logic [PW-1:0] prod_b1 [0:1];
	logic          neg_b1 [0:1];
	logic          inf_b1;
	logic [NW-1:0] den_b1;

	// divider stage registers, index 0 is the entry
	logic          dv_q   [0:QW];
	logic [RW-1:0] rem_q  [0:QW][0:1];
	logic [QW-1:0] quo_q  [0:QW][0:1];
	logic [QW-1:0] low_q  [0:QW][0:1];
	logic          sat_q  [0:QW][0:1];
	logic          neg_q  [0:QW][0:1];
	logic          inf_q  [0:QW];
	logic [NW-1:0] den_q  [0:QW];

	logic          done_q;
	ppv_result_t   result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1   <= 1'b0;
			dv_q   <= '{default: 1'b0};
			done_q <= 1'b0;
		end else begin
			v_b1  <= take;
			dv_q[0] <= v_b1;
			for (int k = 0; k < QW; k++) begin
				dv_q[k+1] <= dv_q[k];
			end
			done_q <= dv_q[QW];
		end
	end

	always_ff @(posedge clk) begin
		prod_b1[0] <= PW'(job.mag_x) * PW'(vp_w);
		prod_b1[1] <= PW'(job.mag_y) * PW'(vp_h);
		neg_b1[0]  <= job.neg_x;
		neg_b1[1]  <= job.neg_y;
		inf_b1     <= job.in_front;
		den_b1     <= job.den;
	end

	// entry: top part of size*num*2^F checked against den for overflow
	always_ff @(posedge clk) begin
		logic [HW-1:0] hi;
		for (int l = 0; l < 2; l++) begin
			hi = prod_b1[l][PW-1:LOWW];
			sat_q[0][l] <= 64'(hi) >= 64'(den_b1);
			rem_q[0][l] <= RW'(hi);
			low_q[0][l] <= {prod_b1[l][LOWW-1:0], {FRAC_BITS{1'b0}}};
			quo_q[0][l] <= '0;
			neg_q[0][l] <= neg_b1[l];
		end
		inf_q[0] <= inf_b1;
		den_q[0] <= den_b1;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		always_ff @(posedge clk) begin
			logic [RW-1:0] t;
			for (int l = 0; l < 2; l++) begin
				t = {rem_q[k][l][RW-2:0], low_q[k][l][QW-1]};
				if (t >= RW'(den_q[k])) begin
					rem_q[k+1][l] <= t - RW'(den_q[k]);
					quo_q[k+1][l] <= {quo_q[k][l][QW-2:0], 1'b1};
				end else begin
					rem_q[k+1][l] <= t;
					quo_q[k+1][l] <= {quo_q[k][l][QW-2:0], 1'b0};
				end
				low_q[k+1][l] <= {low_q[k][l][QW-2:0], 1'b0};
				sat_q[k+1][l] <= sat_q[k][l];
				neg_q[k+1][l] <= neg_q[k][l];
			end
			inf_q[k+1] <= inf_q[k];
			den_q[k+1] <= den_q[k];
		end
	end

	// sign and saturation
	always_ff @(posedge clk) begin
		logic [QW-1:0] v [0:1];
		logic [QW-1:0] q;
		for (int l = 0; l < 2; l++) begin
			q = quo_q[QW][l];
			if (!inf_q[QW]) begin
				v[l] = '0;
			end else if (neg_q[QW][l]) begin
				v[l] = (sat_q[QW][l] || q > {1'b1, {(QW-1){1'b0}}}) ?
					{1'b1, {(QW-1){1'b0}}} : QW'(-q);
			end else begin
				v[l] = (sat_q[QW][l] || q[QW-1]) ? {1'b0, {(QW-1){1'b1}}} : q;
			end
		end
		result_q.in_front <= inf_q[QW];
		result_q.screen_x <= signed'(v[0]);
		result_q.screen_y <= signed'(v[1]);
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
